### hdl/register_file_alu_executor_defines.svh
// assertion macros for the executor checker
`ifndef REGISTER_FILE_ALU_EXECUTOR_DEFINES_SVH
`define REGISTER_FILE_ALU_EXECUTOR_DEFINES_SVH
`define RFE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfe check failed");
`define RFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfe check failed");
`endif

### hdl/rfe_pkg.sv
package rfe_pkg;
   localparam int NUM_REGS   = 26;
   localparam int DATA_WIDTH = 64;
   localparam int IDX_W      = $clog2(NUM_REGS);
   localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

   typedef enum logic [3:0] {
      OP_LOAD = 4'd0, OP_MOVE = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
      OP_MUL = 4'd4, OP_DIV = 4'd5, OP_OUT = 4'd6, OP_XCHG = 4'd7,
      OP_MOD = 4'd8, OP_AND = 4'd9, OP_OR = 4'd10, OP_XOR = 4'd11
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_FIX, ST_WR, ST_WR2, ST_RSP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch request fields
      logic read_ops;   // register operands
      logic mul_start;  // multiply step 1
      logic mul_fin;    // multiply step 2
      logic div_start;
      logic div_step;
      logic div_fix;
      logic alu_load;   // simple alu result into t
      logic wr_first;   // write dest
      logic wr_second;  // write exchange partner
      logic rsp_load;   // load response register
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       div_zero;
      logic       div_done;
   } sts_type;
endpackage

### hdl/rfe_ctrl.sv
module rfe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rfe_pkg::sts_type  sts,
   output rfe_pkg::cmd_type  cmd
);
   import rfe_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (sts.op)
               OP_LOAD, OP_MOVE, OP_XCHG: state_in = ST_WR;
               OP_OUT: state_in = ST_RSP;
               OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: state_in = ST_WR;
               OP_MUL: state_in = ST_MUL;
               OP_DIV, OP_MOD: state_in = sts.div_zero ? ST_RSP : ST_DIV;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MUL: state_in = ST_WR;
         ST_DIV: if (sts.div_done) state_in = ST_FIX;
         ST_FIX: state_in = ST_WR;
         ST_WR: state_in = (sts.op == OP_XCHG) ? ST_WR2 : ST_IDLE;
         ST_WR2: state_in = ST_IDLE;
         ST_RSP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RSP);
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.read_ops = (state_ff == ST_READ);
      cmd.alu_load = (state_ff == ST_EXEC);
      cmd.mul_start = (state_ff == ST_EXEC) && (sts.op == OP_MUL);
      cmd.div_start = (state_ff == ST_EXEC);
      cmd.rsp_load = (state_ff == ST_EXEC);
      cmd.mul_fin = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.div_fix = (state_ff == ST_FIX);
      cmd.wr_first = (state_ff == ST_WR);
      cmd.wr_second = (state_ff == ST_WR2);
   end
endmodule

### hdl/rfe_datapath.sv
module rfe_datapath (
   input  logic             clock,
   input  logic             reset,
   input  rfe_pkg::cmd_type cmd,
   output rfe_pkg::sts_type sts,
   input  logic [3:0]       req_operation,
   input  logic [4:0]       req_dest_reg,
   input  logic [4:0]       req_src_a_reg,
   input  logic [4:0]       req_src_b_reg,
   input  logic             req_three_operand,
   input  logic signed [63:0] req_immediate,
   output logic signed [63:0] rsp_value,
   output logic             rsp_divide_error
);
   import rfe_pkg::*;
   localparam int W = DATA_WIDTH;
   localparam int HW = (W + 1) / 2;

   logic [W-1:0] bank_ff [NUM_REGS];
   logic [3:0]   op_ff;
   logic [4:0]   d_ff, a_ff, b_ff;
   logic         three_ff;
   logic [W-1:0] imm_ff, x_ff, y_ff, da_ff, t_ff;
   logic [W-1:0] pl_ff, ph_ff, pm_ff;
   logic [W-1:0] q_ff, r_ff, ua_ff, ub_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic         neg_q_ff, neg_r_ff, rem_ff;
   logic [W:0]   rtrial;

   function automatic logic [W-1:0] rd(input logic [4:0] i, input logic [W-1:0] v);
      rd = (32'(i) < NUM_REGS) ? v : '0;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation; d_ff <= req_dest_reg; a_ff <= req_src_a_reg;
         b_ff <= req_src_b_reg; three_ff <= req_three_operand;
         imm_ff <= req_immediate[W-1:0];
      end
   end

   // operand read, out-of-range reads as zero
   logic [W-1:0] rdv, rav, rbv;
   always_comb begin
      rdv = rd(d_ff, bank_ff[d_ff[IDX_W-1:0]]);
      rav = rd(a_ff, bank_ff[a_ff[IDX_W-1:0]]);
      rbv = rd(b_ff, bank_ff[b_ff[IDX_W-1:0]]);
   end

   assign sts.op = op_ff;
   assign sts.div_zero = (y_ff == '0);
   // last shift step is under way
   assign sts.div_done = (cnt_ff == CNT_W'(1));

   logic [W-1:0] alu;
   always_comb begin
      unique case (op_ff)
         OP_LOAD: alu = imm_ff;
         OP_MOVE: alu = da_ff;
         OP_ADD:  alu = x_ff + y_ff;
         OP_SUB:  alu = x_ff - y_ff;
         OP_AND:  alu = x_ff & y_ff;
         OP_OR:   alu = x_ff | y_ff;
         OP_XOR:  alu = x_ff ^ y_ff;
         default: alu = da_ff;
      endcase
   end

   // multiply from half-width partial products in two steps: form the products, then sum them
   logic [HW-1:0] xl, xh, yl, yh;
   assign xl = x_ff[HW-1:0];
   assign yl = y_ff[HW-1:0];
   assign xh = HW'(x_ff >> HW);
   assign yh = HW'(y_ff >> HW);

   assign rtrial = {r_ff, ua_ff[W-1]} - {1'b0, ub_ff};

   always_ff @(posedge clock) begin
      if (cmd.read_ops) begin
         x_ff <= three_ff ? rav : rdv;
         y_ff <= three_ff ? rbv : rav;
         da_ff <= rav;
         t_ff <= rdv;   // exchange and output keep old dest here
      end
      if (cmd.mul_start) begin
         pl_ff <= W'((2*HW)'(xl) * (2*HW)'(yl));
         ph_ff <= W'((2*HW)'(xh) * (2*HW)'(yl));
         pm_ff <= W'((2*HW)'(xl) * (2*HW)'(yh));
      end
      if (cmd.div_start) begin
         neg_q_ff <= x_ff[W-1] ^ y_ff[W-1];
         neg_r_ff <= x_ff[W-1];
         rem_ff <= (op_ff == OP_MOD);
         ua_ff <= x_ff[W-1] ? (W'(0) - x_ff) : x_ff;
         ub_ff <= y_ff[W-1] ? (W'(0) - y_ff) : y_ff;
         r_ff <= '0;
         q_ff <= '0;
         cnt_ff <= CNT_W'(W);
      end
      if (cmd.div_step) begin
         if (!rtrial[W]) r_ff <= rtrial[W-1:0];
         else r_ff <= {r_ff[W-2:0], ua_ff[W-1]};
         q_ff <= {q_ff[W-2:0], ~rtrial[W]};
         ua_ff <= {ua_ff[W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.alu_load && op_ff != OP_XCHG) t_ff <= alu;
      if (cmd.mul_fin) t_ff <= pl_ff + ((ph_ff + pm_ff) << HW);
      if (cmd.div_fix) begin
         if (rem_ff) t_ff <= neg_r_ff ? (W'(0) - r_ff) : r_ff;
         else t_ff <= neg_q_ff ? (W'(0) - q_ff) : q_ff;
      end
   end

   // register bank, reset clears all
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) bank_ff[i] <= '0;
      end else begin
         if (cmd.wr_first && 32'(d_ff) < NUM_REGS && op_ff <= OP_XOR
             && op_ff != OP_OUT && op_ff != OP_DIV && op_ff != OP_MOD)
            bank_ff[d_ff[IDX_W-1:0]] <= (op_ff == OP_XCHG) ? da_ff : t_ff;
         if (cmd.wr_first && 32'(d_ff) < NUM_REGS
             && (op_ff == OP_DIV || op_ff == OP_MOD))
            bank_ff[d_ff[IDX_W-1:0]] <= t_ff;
         if (cmd.wr_second && 32'(a_ff) < NUM_REGS)
            bank_ff[a_ff[IDX_W-1:0]] <= t_ff;
      end
   end

   // t still holds the dest register while the response loads
   logic [W-1:0] rsp_raw_ff;
   logic         err_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         err_ff <= (op_ff != OP_OUT);
         rsp_raw_ff <= (op_ff == OP_OUT) ? t_ff : '0;
      end
   end
   assign rsp_value = 64'(signed'(rsp_raw_ff));
   assign rsp_divide_error = err_ff;
endmodule

### hdl/register_file_alu_executor.sv
// accept to next accept: read, execute, then write; exchange adds a second write, mul a multiply
//   state, div/mod the divide states and a fix state; output and divide-by-zero go from execute
//   to a response held valid until taken, next accept in the cycle after it is taken
// throughput: one item at a time; div/mod use a 64-step shift-subtract divider
// reset: synchronous, clears the controller and all bank registers
module register_file_alu_executor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_operation,
   input  logic [4:0]        req_dest_reg,
   input  logic [4:0]        req_src_a_reg,
   input  logic [4:0]        req_src_b_reg,
   input  logic              req_three_operand,
   input  logic signed [63:0] req_immediate,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [63:0] rsp_value,
   output logic              rsp_divide_error
);
   import rfe_pkg::*;
   cmd_type cmd;
   sts_type sts;

   // controller sequences one beat through read, execute, multiply or divide, and write or response
   rfe_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .rsp_valid,
      .rsp_ready, .sts, .cmd);

   // datapath owns the bank, alu, multiplier and divider
   rfe_datapath u_dp (.clock, .reset, .cmd, .sts, .req_operation, .req_dest_reg,
      .req_src_a_reg, .req_src_b_reg, .req_three_operand, .req_immediate,
      .rsp_value, .rsp_divide_error);
endmodule

### hdl/rfe_checker.sv
`include "register_file_alu_executor_defines.svh"
module rfe_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [63:0] rsp_value,
   input logic rsp_divide_error
);
   `RFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
   `RFE_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_divide_error, rsp_value == 64'sd0)
   `RFE_ASSERT_IMPL(a_no_ready_busy, clock, reset, rsp_valid, !req_ready)
   `RFE_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind register_file_alu_executor rfe_checker u_chk (.clock, .reset, .req_valid, .req_ready,
   .rsp_valid, .rsp_ready, .rsp_value, .rsp_divide_error);

### dv/tb_register_file_alu_executor.sv
`timescale 1ns / 100ps

module tb_register_file_alu_executor;
   import rfe_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [3:0]        req_operation;
   logic [4:0]        req_dest_reg;
   logic [4:0]        req_src_a_reg;
   logic [4:0]        req_src_b_reg;
   logic              req_three_operand;
   logic signed [63:0] req_immediate;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [63:0] rsp_value;
   logic              rsp_divide_error;

   register_file_alu_executor dut (.*);

   // one expected response beat
   typedef struct packed {
      logic [63:0] value;
      logic        divide_error;
   } rsp_beat_type;

   // one instruction beat; has_exp marks rows with a typed-in answer
   typedef struct packed {
      logic [3:0]  op;
      logic [4:0]  dest;
      logic [4:0]  src_a;
      logic [4:0]  src_b;
      logic        three;
      logic [63:0] imm;
      logic        has_exp;
      rsp_beat_type exp;
   } instr_type;

   localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONE = 64'hffff_ffff_ffff_ffff;
   localparam logic [3:0]  OP_SPARE = 4'd13;   // unused code, does nothing
   localparam int          N_RANDOM = 1800;

   // shadow register bank and pending responses
   logic [63:0] shadow_bank [NUM_REGS];
   rsp_beat_type pending_rsp [$];
   instr_type   directed [$];

   int  n_errors;
   int  n_rsp_seen;
   int  n_div_err_seen;
   int  n_sent;
   bit  stall_free;   // long stretch with no idling on either side

   always #5 clock = ~clock;

   function automatic logic [63:0] bank_read(logic [4:0] idx);
      return (idx < NUM_REGS) ? shadow_bank[idx] : 64'd0;
   endfunction

   function automatic void bank_write(logic [4:0] idx, logic [63:0] v);
      if (idx < NUM_REGS) shadow_bank[idx] = v;
   endfunction

   // signed truncating divide or remainder, divisor nonzero
   function automatic logic [63:0] trunc_divmod(logic [63:0] a, logic [63:0] b, bit want_rem);
      logic        neg_a;
      logic        neg_b;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] r;
      neg_a = a[63];
      neg_b = b[63];
      mag_a = neg_a ? -a : a;
      mag_b = neg_b ? -b : b;
      if (want_rem) begin
         r = mag_a % mag_b;
         return neg_a ? -r : r;
      end
      r = mag_a / mag_b;
      return (neg_a != neg_b) ? -r : r;
   endfunction

   // apply one instruction to the shadow bank, queue any response it makes
   function automatic void execute_instr(instr_type it);
      logic [63:0] x, y, t;
      rsp_beat_type r;
      case (it.op)
         OP_LOAD: begin
            bank_write(it.dest, it.imm);
            return;
         end
         OP_MOVE: begin
            bank_write(it.dest, bank_read(it.src_a));
            return;
         end
         OP_OUT: begin
            r.value        = bank_read(it.dest);
            r.divide_error = 1'b0;
            pending_rsp.push_back(r);
            return;
         end
         OP_XCHG: begin
            t = bank_read(it.dest);
            bank_write(it.dest, bank_read(it.src_a));
            bank_write(it.src_a, t);
            return;
         end
         default: ;
      endcase
      if (it.op > OP_XOR) return;
      if (it.three) begin
         x = bank_read(it.src_a);
         y = bank_read(it.src_b);
      end else begin
         x = bank_read(it.dest);
         y = bank_read(it.src_a);
      end
      case (it.op)
         OP_ADD: t = x + y;
         OP_SUB: t = x - y;
         OP_MUL: t = x * y;
         OP_AND: t = x & y;
         OP_OR:  t = x | y;
         OP_XOR: t = x ^ y;
         default: begin
            if (y == 64'd0) begin
               r.value        = 64'd0;
               r.divide_error = 1'b1;
               pending_rsp.push_back(r);
               return;
            end
            t = trunc_divmod(x, y, it.op == OP_MOD);
         end
      endcase
      bank_write(it.dest, t);
   endfunction

   function automatic instr_type mk(logic [3:0] op, int d, int a, int b, bit three,
                                    logic [63:0] imm);
      instr_type it;
      it.op      = op;
      it.dest    = d[4:0];
      it.src_a   = a[4:0];
      it.src_b   = b[4:0];
      it.three   = three;
      it.imm     = imm;
      it.has_exp = 1'b0;
      it.exp     = '0;
      return it;
   endfunction

   // same, with the response typed in
   function automatic instr_type mk_exp(instr_type it, logic [63:0] v, bit derr);
      it.has_exp          = 1'b1;
      it.exp.value        = v;
      it.exp.divide_error = derr;
      return it;
   endfunction

   function automatic int rand_idx();
      // mostly in range, sometimes out of range up to 31
      return ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_REGS, 31)
                                         : $urandom_range(0, NUM_REGS - 1);
   endfunction

   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 7))
         0: return MIN_VAL;
         1: return MAX_VAL;
         2: return ALL_ONE;
         3: return 64'd0;
         4: return 64'($signed($urandom_range(0, 20)) - 10);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one random instruction, weighted toward alu, divide and modulo ops
   function automatic instr_type rand_instr();
      logic [3:0] op;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)      op = OP_LOAD;
      else if (pick < 25) op = OP_OUT;
      else if (pick < 30) op = OP_MOVE;
      else if (pick < 35) op = OP_XCHG;
      else if (pick < 48) op = OP_DIV;
      else if (pick < 60) op = OP_MOD;
      else if (pick < 97) op = 4'($urandom_range(OP_ADD, OP_XOR));
      else                op = 4'($urandom_range(12, 15));
      return mk(op, rand_idx(), rand_idx(), rand_idx(), 1'($urandom),
                rand_value());
   endfunction

   function automatic bit idle_now();
      return !stall_free && ($urandom_range(0, 99) < 31);
   endfunction

   // drive one instruction beat from the next falling edge, wait for acceptance
   task automatic send_instr(instr_type it);
      @(negedge clock);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= it.op;
      req_dest_reg      <= it.dest;
      req_src_a_reg     <= it.src_a;
      req_src_b_reg     <= it.src_b;
      req_three_operand <= it.three;
      req_immediate     <= it.imm;
      do @(posedge clock); while (!req_ready);
      // predictor runs at the accepting edge, before any response can arrive
      if (it.has_exp) begin
         execute_instr(it);
         if (pending_rsp.size() != 0) pending_rsp[$] = it.exp;
      end else begin
         execute_instr(it);
      end
      n_sent++;
   endtask

   // response side: random stalls, compare on every accepted beat
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= !idle_now();
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response beat value=%h divide_error=%b",
                     $time, rsp_value, rsp_divide_error);
            n_errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_divide_error) n_div_err_seen++;
            if (rsp_value !== want.value) begin
               $display("%0t: value mismatch expected=%h actual=%h",
                        $time, want.value, rsp_value);
               n_errors++;
            end
            if (rsp_divide_error !== want.divide_error) begin
               $display("%0t: divide_error mismatch expected=%b actual=%b",
                        $time, want.divide_error, rsp_divide_error);
               n_errors++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #50ms;
      $display("%0t: timeout", $time);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int wait_cycles;
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_LOAD;
      req_dest_reg      = '0;
      req_src_a_reg     = '0;
      req_src_b_reg     = '0;
      req_three_operand = 1'b0;
      req_immediate     = '0;
      rsp_ready         = 1'b0;
      stall_free        = 1'b0;
      n_errors          = 0;
      n_rsp_seen        = 0;
      n_div_err_seen    = 0;
      n_sent            = 0;
      foreach (shadow_bank[i]) shadow_bank[i] = '0;

      // directed rows: typed-in answers for reset state, extremes, errors
      directed.push_back(mk_exp(mk(OP_OUT, 0, 0, 0, 0, 0), 64'd0, 0));
      directed.push_back(mk_exp(mk(OP_OUT, 25, 0, 0, 0, 0), 64'd0, 0));
      directed.push_back(mk_exp(mk(OP_DIV, 3, 4, 5, 1, 0), 64'd0, 1));
      directed.push_back(mk_exp(mk(OP_MOD, 3, 4, 0, 0, 0), 64'd0, 1));
      directed.push_back(mk(OP_LOAD, 0, 0, 0, 0, MIN_VAL));
      directed.push_back(mk(OP_LOAD, 1, 0, 0, 0, ALL_ONE));
      directed.push_back(mk(OP_LOAD, 25, 0, 0, 0, MAX_VAL));
      directed.push_back(mk_exp(mk(OP_OUT, 0, 0, 0, 0, 0), MIN_VAL, 0));
      directed.push_back(mk_exp(mk(OP_OUT, 25, 0, 0, 0, 0), MAX_VAL, 0));
      // min divided by minus one wraps, remainder zero
      directed.push_back(mk(OP_DIV, 2, 0, 1, 1, 0));
      directed.push_back(mk_exp(mk(OP_OUT, 2, 0, 0, 0, 0), MIN_VAL, 0));
      directed.push_back(mk(OP_MOD, 3, 0, 1, 1, 0));
      directed.push_back(mk_exp(mk(OP_OUT, 3, 0, 0, 0, 0), 64'd0, 0));
      // out-of-range index reads zero, write ignored
      directed.push_back(mk(OP_LOAD, 31, 0, 0, 0, MAX_VAL));
      directed.push_back(mk_exp(mk(OP_OUT, 31, 0, 0, 0, 0), 64'd0, 0));
      directed.push_back(mk(OP_XCHG, 25, 30, 0, 0, 0));
      directed.push_back(mk(OP_MOVE, 4, 1, 0, 0, 0));
      directed.push_back(mk(OP_ADD, 4, 25, 0, 0, 0));
      directed.push_back(mk(OP_SUB, 5, 0, 1, 1, 0));
      directed.push_back(mk(OP_MUL, 6, 25, 25, 1, 0));
      directed.push_back(mk(OP_AND, 1, 25, 0, 0, 0));
      directed.push_back(mk(OP_OR, 7, 0, 25, 1, 0));
      directed.push_back(mk(OP_XOR, 7, 1, 0, 0, 0));
      directed.push_back(mk(OP_SPARE, 7, 1, 2, 1, ALL_ONE));
      directed.push_back(mk(OP_OUT, 7, 0, 0, 0, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_instr(directed[i]);

      for (int k = 0; k < N_RANDOM; k++) begin
         stall_free = (k >= 600 && k < 800);
         send_instr(rand_instr());
      end
      stall_free = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // drain the pending responses, then let the bench idle before the summary
      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);

      $display("%0d instructions sent, %0d response beats checked (%0d divide errors)",
               n_sent, n_rsp_seen, n_div_err_seen);
      if (n_errors == 0 && pending_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d responses never arrived",
                  n_errors, pending_rsp.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
